/* src/plane_quad_corner_generator_unit_assert.svh */
// assertion macros for the plane quad corner generator checker
// no dependencies; include once per file that asserts
`ifndef PLANE_QUAD_CORNER_GENERATOR_UNIT_ASSERT_SVH
`define PLANE_QUAD_CORNER_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define PQCG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pqcg check failed");

// next-cycle implication
`define PQCG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pqcg check failed");

`endif

/* src/pqcg_pkg.sv */
// shared types and constants of the plane quad corner generator
// no dependencies
package pqcg_pkg;

   // per-plane context that travels down the pipeline
   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic [2:0]         sign_a;
      logic [2:0]         sign_b;
      logic               zero;
   } ctx_type;

   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_sel_type;

   // axis test: 100*nz^2 < 81*|n|^2
   localparam int TEST_NUM = 100;
   localparam int TEST_DEN = 81;

   // corner k takes the negative width / height offset where the bit is set
   localparam logic [3:0] NEG_W = 4'b1001;
   localparam logic [3:0] NEG_H = 4'b0011;

   localparam logic [1:0] LAST_CORNER = 2'd3;

endpackage

/* src/plane_quad_corner_generator_unit.sv */
// plane quad corner generator: in-plane basis and rectangle corners
// throughput: set by the four corner transfers of the
//   result channel; the inner pipeline takes an item in any cycle it advances
// reset: synchronous, active high; clears valid bits, corner count and sets
//   width and height to 1.0; depends on pqcg_pkg
module plane_quad_corner_generator_unit import pqcg_pkg::*; #(
   parameter int UNIT_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_center_z,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_corner_x,
   output logic signed [31:0] rsp_corner_y,
   output logic signed [31:0] rsp_corner_z,
   output logic [1:0]         rsp_corner_index,
   output logic               rsp_last_corner,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int F   = UNIT_FRAC_BITS;
   localparam int QW  = F + 1;          // quotient bits of a unit component
   localparam int NW  = F + 32;         // dividend bits
   localparam int PW  = 32 + QW;        // size times unit component
   localparam int SQN = 32;             // root bits
   localparam int NST = F + 44;         // pipeline stages before the output slot

   // stage map:
   //   0 products, 1 sums, 2 axis select, 3 max, 4 leading zeros, 5 shift,
   //   6 squares, 7 length^2, 8..39 root bit per stage, 40 dividend,
   //   41..41+F quotient bit per stage, 42+F size products, 43+F rounding

   // ---------------------------------------------------------------- registers
   logic [31:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 32'd65536;
         height_ff <= 32'd65536;
      end else if (psel && penable && pwrite && pready) begin
         unique case (reg_sel_type'(paddr[2]))
            REG_WIDTH:  width_ff  <= pwdata;
            REG_HEIGHT: height_ff <= pwdata;
         endcase
      end
   end

   assign pready = 1'b1;

   always_comb begin
      unique case (reg_sel_type'(paddr[2]))
         REG_WIDTH:  prdata = width_ff;
         REG_HEIGHT: prdata = height_ff;
      endcase
   end

   // ---------------------------------------------------------------- control
   // the whole pipeline moves together; it moves whenever the output slot
   // is empty or is handing over its last corner
   logic          adv;
   logic          v_ff [NST];
   ctx_type       ctx_ff [NST];
   logic          o_v_ff;
   logic [1:0]    o_k_ff;

   assign adv       = !o_v_ff || (rsp_ready && (o_k_ff == LAST_CORNER));
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NST; s++) begin
            v_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         v_ff[0] <= req_valid;
         for (int s = 1; s < NST; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
      end
   end

   // ---------------------------------------------------------------- stages 0..2
   logic signed [15:0] n1_ff [3];
   logic [31:0]        sq1_ff [3];        // nx^2, ny^2, nz^2
   logic signed [31:0] cr1_ff [3];        // nx*ny, nx*nz, ny*nz

   logic signed [15:0] n2_ff [3];
   logic signed [31:0] cr2_ff [3];
   logic [32:0]        len2_ff, sxy2_ff, syz2_ff;
   logic [31:0]        sqz2_ff;

   logic [31:0]        mag3_ff [2][3];
   ctx_type            ctx3_in;
   logic [31:0]        mag3_in [2][3];
   logic               z_cross;

   function automatic logic [31:0] abs16(input logic signed [15:0] v);
      logic signed [16:0] w;
      begin
         w = 17'(v);
         abs16 = 32'(unsigned'(w < 0 ? -w : w));
      end
   endfunction

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      abs32 = unsigned'(v < 0 ? -v : v);
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         n1_ff[0]  <= req_normal_x;
         n1_ff[1]  <= req_normal_y;
         n1_ff[2]  <= req_normal_z;
         sq1_ff[0] <= unsigned'(32'(req_normal_x * req_normal_x));
         sq1_ff[1] <= unsigned'(32'(req_normal_y * req_normal_y));
         sq1_ff[2] <= unsigned'(32'(req_normal_z * req_normal_z));
         cr1_ff[0] <= 32'(req_normal_x * req_normal_y);
         cr1_ff[1] <= 32'(req_normal_x * req_normal_z);
         cr1_ff[2] <= 32'(req_normal_y * req_normal_z);

         n2_ff   <= n1_ff;
         cr2_ff  <= cr1_ff;
         len2_ff <= 33'(sq1_ff[0]) + 33'(sq1_ff[1]) + 33'(sq1_ff[2]);
         sxy2_ff <= 33'(sq1_ff[0]) + 33'(sq1_ff[1]);
         syz2_ff <= 33'(sq1_ff[1]) + 33'(sq1_ff[2]);
         sqz2_ff <= sq1_ff[2];

         mag3_ff   <= mag3_in;
      end
   end

   // axis select: normal x Z unless the normal is steep, then normal x X
   assign z_cross = (41'(sqz2_ff) * 41'(TEST_NUM)) < (41'(len2_ff) * 41'(TEST_DEN));

   always_comb begin
      ctx3_in      = ctx_ff[1];
      ctx3_in.zero = (len2_ff == '0);
      if (z_cross) begin
         // a = (ny, -nx, 0), b = (nx*nz, ny*nz, -(nx^2+ny^2))
         mag3_in[0][0]  = abs16(n2_ff[1]);
         mag3_in[0][1]  = abs16(n2_ff[0]);
         mag3_in[0][2]  = '0;
         ctx3_in.sign_a = {1'b0, n2_ff[0] > 0, n2_ff[1] < 0};
         mag3_in[1][0]  = abs32(cr2_ff[1]);
         mag3_in[1][1]  = abs32(cr2_ff[2]);
         mag3_in[1][2]  = sxy2_ff[31:0];
         ctx3_in.sign_b = {1'b1, cr2_ff[2] < 0, cr2_ff[1] < 0};
      end else begin
         // a = (0, nz, -ny), b = (-(ny^2+nz^2), nx*ny, nx*nz)
         mag3_in[0][0]  = '0;
         mag3_in[0][1]  = abs16(n2_ff[2]);
         mag3_in[0][2]  = abs16(n2_ff[1]);
         ctx3_in.sign_a = {n2_ff[1] > 0, n2_ff[2] < 0, 1'b0};
         mag3_in[1][0]  = syz2_ff[31:0];
         mag3_in[1][1]  = abs32(cr2_ff[0]);
         mag3_in[1][2]  = abs32(cr2_ff[1]);
         ctx3_in.sign_b = {cr2_ff[1] < 0, cr2_ff[0] < 0, 1'b1};
      end
   end

   // per-plane context walks one stage per advance; stage 2 picks up the signs
   always_ff @(posedge clock) begin
      if (adv) begin
         ctx_ff[0] <= '{cx: req_center_x, cy: req_center_y, cz: req_center_z,
                        sign_a: 3'b000, sign_b: 3'b000, zero: 1'b0};
         ctx_ff[1] <= ctx_ff[0];
         ctx_ff[2] <= ctx3_in;
         for (int s = 3; s < NST; s++) begin
            ctx_ff[s] <= ctx_ff[s-1];
         end
      end
   end

   // ---------------------------------------------------------------- stages 3..7
   // scale each axis so its largest magnitude lands in [2^30, 2^31)
   logic [31:0] mag4_ff [2][3];
   logic [31:0] top4_ff [2];
   logic [31:0] mag5_ff [2][3];
   logic [5:0]  lz5_ff [2];
   logic [30:0] nm6_ff [2][3];
   logic [30:0] nm7_ff [2][3];
   logic [61:0] sqr7_ff [2][3];

   function automatic logic [31:0] max3(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
      logic [31:0] m;
      begin
         m    = (a > b) ? a : b;
         max3 = (m > c) ? m : c;
      end
   endfunction

   function automatic logic [5:0] lead_zeros(input logic [31:0] v);
      logic [5:0] n;
      begin
         n = 6'd32;
         for (int b = 0; b < 32; b++) begin
            if (v[b]) n = 6'(31 - b);
         end
         lead_zeros = n;
      end
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         mag4_ff <= mag3_ff;
         mag5_ff <= mag4_ff;
         nm7_ff  <= nm6_ff;
         for (int ax = 0; ax < 2; ax++) begin
            top4_ff[ax] <= max3(mag3_ff[ax][0], mag3_ff[ax][1], mag3_ff[ax][2]);
            lz5_ff[ax]  <= lead_zeros(top4_ff[ax]);
            for (int i = 0; i < 3; i++) begin
               // shift left by lz, then right by one (truncates when lz is zero)
               nm6_ff[ax][i]  <= 31'(({1'b0, mag5_ff[ax][i]} << lz5_ff[ax]) >> 1);
               sqr7_ff[ax][i] <= 62'(nm6_ff[ax][i]) * 62'(nm6_ff[ax][i]);
            end
         end
      end
   end

   // ---------------------------------------------------------------- square root
   // one root bit per stage, remainder form
   logic [63:0] sq_rad_ff  [SQN+1][2];
   logic [33:0] sq_rem_ff  [SQN+1][2];
   logic [31:0] sq_root_ff [SQN+1][2];
   logic [30:0] sq_nm_ff   [SQN+1][2][3];
   logic [33:0] sq_rem_in  [SQN][2];
   logic [31:0] sq_root_in [SQN][2];

   always_comb begin : sqrt_step
      logic [35:0] r, t;
      for (int j = 0; j < SQN; j++) begin
         for (int ax = 0; ax < 2; ax++) begin
            r = {sq_rem_ff[j][ax], sq_rad_ff[j][ax][63:62]};
            t = {2'b00, sq_root_ff[j][ax], 2'b01};
            if (r >= t) begin
               sq_rem_in[j][ax]  = 34'(r - t);
               sq_root_in[j][ax] = {sq_root_ff[j][ax][30:0], 1'b1};
            end else begin
               sq_rem_in[j][ax]  = r[33:0];
               sq_root_in[j][ax] = {sq_root_ff[j][ax][30:0], 1'b0};
            end
         end
      end
   end

   // stage 7 writes entry 0 of the root arrays
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int ax = 0; ax < 2; ax++) begin
            sq_rad_ff[0][ax]  <= 64'(sqr7_ff[ax][0]) + 64'(sqr7_ff[ax][1])
                               + 64'(sqr7_ff[ax][2]);
            sq_rem_ff[0][ax]  <= '0;
            sq_root_ff[0][ax] <= '0;
            sq_nm_ff[0][ax]   <= nm7_ff[ax];
         end
         for (int j = 0; j < SQN; j++) begin
            for (int ax = 0; ax < 2; ax++) begin
               sq_rad_ff[j+1][ax]  <= {sq_rad_ff[j][ax][61:0], 2'b00};
               sq_rem_ff[j+1][ax]  <= sq_rem_in[j][ax];
               sq_root_ff[j+1][ax] <= sq_root_in[j][ax];
               sq_nm_ff[j+1][ax]   <= sq_nm_ff[j][ax];
            end
         end
      end
   end

   // ---------------------------------------------------------------- division
   // component = round(m * 2^F / S), one quotient bit per stage
   logic [NW-1:0] dv_n_ff   [QW+1][2][3];
   logic [31:0]   dv_rem_ff [QW+1][2][3];
   logic [QW-1:0] dv_q_ff   [QW+1][2][3];
   logic [31:0]   dv_s_ff   [QW+1][2];
   logic [31:0]   dv_rem_in [QW][2][3];
   logic          dv_bit_in [QW][2][3];
   logic [NW-1:0] dv_num_in [2][3];

   always_comb begin
      for (int ax = 0; ax < 2; ax++) begin
         for (int i = 0; i < 3; i++) begin
            dv_num_in[ax][i] = NW'({sq_nm_ff[SQN][ax][i], {F{1'b0}}})
                             + NW'(sq_root_ff[SQN][ax][31:1]);
         end
      end
   end

   always_comb begin : div_step
      logic [32:0] tr;
      for (int m = 0; m < QW; m++) begin
         for (int ax = 0; ax < 2; ax++) begin
            for (int i = 0; i < 3; i++) begin
               tr = {dv_rem_ff[m][ax][i], dv_n_ff[m][ax][i][QW-1-m]};
               if (tr >= {1'b0, dv_s_ff[m][ax]}) begin
                  dv_rem_in[m][ax][i] = 32'(tr - {1'b0, dv_s_ff[m][ax]});
                  dv_bit_in[m][ax][i] = 1'b1;
               end else begin
                  dv_rem_in[m][ax][i] = tr[31:0];
                  dv_bit_in[m][ax][i] = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int ax = 0; ax < 2; ax++) begin
            dv_s_ff[0][ax] <= sq_root_ff[SQN][ax];
            for (int i = 0; i < 3; i++) begin
               dv_n_ff[0][ax][i]   <= dv_num_in[ax][i];
               dv_rem_ff[0][ax][i] <= 32'(dv_num_in[ax][i][NW-1:QW]);
               dv_q_ff[0][ax][i]   <= '0;
            end
         end
         for (int m = 0; m < QW; m++) begin
            for (int ax = 0; ax < 2; ax++) begin
               dv_s_ff[m+1][ax] <= dv_s_ff[m][ax];
               for (int i = 0; i < 3; i++) begin
                  dv_n_ff[m+1][ax][i]   <= dv_n_ff[m][ax][i];
                  dv_rem_ff[m+1][ax][i] <= dv_rem_in[m][ax][i];
                  dv_q_ff[m+1][ax][i]   <= {dv_q_ff[m][ax][i][QW-2:0],
                                            dv_bit_in[m][ax][i]};
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- half offsets
   logic [PW-1:0]      pw_ff [3], ph_ff [3];
   logic signed [33:0] hw_ff [3], hh_ff [3];

   function automatic logic signed [33:0] half_round(input logic [PW-1:0] p,
                                                     input logic neg,
                                                     input logic zero);
      logic [PW-1:0] t;
      logic [33:0]   h;
      begin
         t = p + (PW'(1) << F);
         h = 34'(t[PW-1:F+1]);
         if (zero)     half_round = '0;
         else if (neg) half_round = -signed'(h);
         else          half_round = signed'(h);
      end
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            pw_ff[i] <= PW'(width_ff)  * PW'(dv_q_ff[QW][0][i]);
            ph_ff[i] <= PW'(height_ff) * PW'(dv_q_ff[QW][1][i]);
            hw_ff[i] <= half_round(pw_ff[i], ctx_ff[NST-2].sign_a[i], ctx_ff[NST-2].zero);
            hh_ff[i] <= half_round(ph_ff[i], ctx_ff[NST-2].sign_b[i], ctx_ff[NST-2].zero);
         end
      end
   end

   // ---------------------------------------------------------------- output slot
   // holds one plane and hands out its four corners, one per transfer
   ctx_type            o_ctx_ff;
   logic signed [33:0] o_hw_ff [3], o_hh_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
         o_k_ff <= '0;
      end else if (adv) begin
         o_v_ff <= v_ff[NST-1];
         o_k_ff <= '0;
      end else if (rsp_ready) begin
         o_k_ff <= o_k_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_ctx_ff <= ctx_ff[NST-1];
         o_hw_ff  <= hw_ff;
         o_hh_ff  <= hh_ff;
      end
   end

   function automatic logic signed [31:0] corner(input logic signed [31:0] c,
                                                 input logic signed [33:0] hw,
                                                 input logic signed [33:0] hh,
                                                 input logic negw,
                                                 input logic negh);
      logic signed [35:0] w, h, s;
      begin
         w = {{2{hw[33]}}, hw};
         h = {{2{hh[33]}}, hh};
         s = {{4{c[31]}}, c} + (negw ? -w : w) + (negh ? -h : h);
         if (s > 36'sh0_7FFF_FFFF)       corner = 32'sh7FFF_FFFF;
         else if (s < -36'sh0_8000_0000) corner = 32'sh8000_0000;
         else                            corner = s[31:0];
      end
   endfunction

   assign rsp_valid        = o_v_ff;
   assign rsp_corner_index = o_k_ff;
   assign rsp_last_corner  = (o_k_ff == LAST_CORNER);
   assign rsp_corner_x     = corner(o_ctx_ff.cx, o_hw_ff[0], o_hh_ff[0],
                                    NEG_W[o_k_ff], NEG_H[o_k_ff]);
   assign rsp_corner_y     = corner(o_ctx_ff.cy, o_hw_ff[1], o_hh_ff[1],
                                    NEG_W[o_k_ff], NEG_H[o_k_ff]);
   assign rsp_corner_z     = corner(o_ctx_ff.cz, o_hw_ff[2], o_hh_ff[2],
                                    NEG_W[o_k_ff], NEG_H[o_k_ff]);

endmodule

/* src/pqcg_checker.sv */
// port-level checks of the plane quad corner generator, bound to the top level
// depends on pqcg_pkg and plane_quad_corner_generator_unit_assert.svh
`include "plane_quad_corner_generator_unit_assert.svh"

module pqcg_checker import pqcg_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_corner_x,
   input logic signed [31:0] rsp_corner_y,
   input logic signed [31:0] rsp_corner_z,
   input logic [1:0]         rsp_corner_index,
   input logic               rsp_last_corner
);

   // a stalled corner holds
   `PQCG_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_corner_x) && $stable(rsp_corner_y) && $stable(rsp_corner_z) && $stable(rsp_corner_index))

   // corners of one plane follow in order
   `PQCG_ASSERT_NXT(a_idx_step, clock, reset, rsp_valid && rsp_ready && !rsp_last_corner, rsp_valid && (rsp_corner_index == 2'($past(rsp_corner_index) + 2'd1)))

   // last flag marks the fourth corner only
   `PQCG_ASSERT_NOW(a_last_flag, clock, reset, rsp_valid, rsp_last_corner == (rsp_corner_index == LAST_CORNER))

   // no new plane enters while the output slot still owes corners
   `PQCG_ASSERT_NOW(a_no_take, clock, reset, rsp_valid && !(rsp_ready && rsp_last_corner), !req_ready)

endmodule

bind plane_quad_corner_generator_unit pqcg_checker u_pqcg_checker (.*);
